// ----- sv/sctc_pkg.sv -----
package sctc_pkg;

	localparam int BANKS     = 4;
	localparam int CAS_LIMIT = 8;
	localparam int BANK_W    = 2;
	localparam int CAS_W     = (CAS_LIMIT > 1) ? $clog2(CAS_LIMIT) : 1;

	typedef enum logic [2:0] {
		CMD_OTHER = 3'd0,
		CMD_ACT   = 3'd1,
		CMD_PRE   = 3'd2,
		CMD_RD    = 3'd3,
		CMD_WR    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		REG_T_RC  = 3'd0,
		REG_T_RCD = 3'd1,
		REG_T_RAS = 3'd2,
		REG_T_RP  = 3'd3,
		REG_T_RRD = 3'd4,
		REG_T_WR  = 3'd5,
		REG_T_CL  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [5:0] t_rc;
		logic [4:0] t_rcd;
		logic [5:0] t_ras;
		logic [4:0] t_rp;
		logic [4:0] t_rrd;
		logic [4:0] t_wr;
		logic [4:0] t_cl;
	} cfg_t;

	typedef struct packed {
		logic              chip_select_n;
		logic              clock_enable;
		logic [2:0]        req_type;
		logic [BANK_W-1:0] cmd_bank;
		logic [3:0]        cas_length;
		logic [2:0]        query_type;
		logic [BANK_W-1:0] query_bank;
	} item_t;

	typedef struct packed {
		logic [BANKS-1:0] act_ok;
		logic [BANKS-1:0] pre_ok;
		logic [BANKS-1:0] rd_ok;
		logic [BANKS-1:0] wr_ok;
		logic             query_allowed;
	} result_t;

	function automatic logic [5:0] minus_one(input logic [5:0] v);
		return (v == 6'd0) ? 6'd0 : v - 6'd1;
	endfunction

endpackage

// ----- sv/sctc_timer.sv -----
module sctc_timer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  sctc_pkg::item_t item,
	input  sctc_pkg::cfg_t  cfg,
	output sctc_pkg::result_t res_q
);
	import sctc_pkg::*;

	// bus counters; no bus precharge counter is kept, so precharge waits on the bank alone
	logic [4:0]       bus_act_q, bus_act_n;
	logic [CAS_W-1:0] bus_rd_q, bus_rd_n;
	logic [6:0]       bus_wr_q, bus_wr_n;

	logic [5:0] bank_act_q [BANKS];
	logic [5:0] bank_pre_q [BANKS];
	logic [4:0] bank_rd_q  [BANKS];
	logic [4:0] bank_wr_q  [BANKS];
	logic [5:0] bank_act_n [BANKS];
	logic [5:0] bank_pre_n [BANKS];
	logic [4:0] bank_rd_n  [BANKS];
	logic [4:0] bank_wr_n  [BANKS];

	logic       cmd_vld;
	logic [3:0] cas_m1;
	logic [CAS_W-1:0] burst;
	logic [4:0] lim_bus_act;
	logic [CAS_W-1:0] lim_bus_rd;
	logic [6:0] lim_bus_wr;
	logic [5:0] lim_act, lim_pre;
	logic [4:0] lim_rw;
	logic [5:0] rcd_rp;
	logic [3:0] flags [BANKS];
	result_t    res_n;

	assign cmd_vld = !item.chip_select_n && item.clock_enable;
	assign cas_m1  = (item.cas_length == 4'd0) ? 4'd0 : item.cas_length - 4'd1;
	assign burst   = (32'(cas_m1) > CAS_LIMIT - 1) ? CAS_W'(CAS_LIMIT - 1) : CAS_W'(cas_m1);
	assign rcd_rp  = {1'b0, cfg.t_rcd} + {1'b0, cfg.t_rp};

	always_comb begin
		lim_bus_act = '0;
		lim_bus_rd  = '0;
		lim_bus_wr  = '0;
		lim_act     = '0;
		lim_pre     = '0;
		lim_rw      = '0;
		case (item.req_type)
			CMD_ACT: begin
				if (rcd_rp < cfg.t_rc)
					lim_act = minus_one(cfg.t_rc);
				lim_rw      = 5'(minus_one({1'b0, cfg.t_rcd}));
				lim_pre     = minus_one(cfg.t_ras);
				lim_bus_act = 5'(minus_one({1'b0, cfg.t_rrd}));
			end
			CMD_PRE: begin
				lim_act = minus_one({1'b0, cfg.t_rp});
			end
			CMD_RD: begin
				lim_pre     = 6'(burst);
				lim_bus_rd  = burst;
				lim_bus_wr  = 7'(burst) + 7'(cfg.t_wr) + 7'(cfg.t_cl);
			end
			CMD_WR: begin
				lim_pre     = 6'(burst);
				lim_bus_rd  = burst;
				lim_bus_wr  = 7'(burst);
			end
			default: ;
		endcase
	end

	// bus: count down, then raise
	always_comb begin
		bus_act_n = (bus_act_q == '0) ? '0 : bus_act_q - 5'd1;
		bus_rd_n  = (bus_rd_q == '0) ? '0 : bus_rd_q - CAS_W'(1);
		bus_wr_n  = (bus_wr_q == '0) ? '0 : bus_wr_q - 7'd1;
		if (cmd_vld) begin
			if (bus_act_n < lim_bus_act) bus_act_n = lim_bus_act;
			if (bus_rd_n < lim_bus_rd)   bus_rd_n  = lim_bus_rd;
			if (bus_wr_n < lim_bus_wr)   bus_wr_n  = lim_bus_wr;
		end
	end

	// banks: raise, take flags, then count down
	always_comb begin
		logic       hit;
		logic [5:0] a, p;
		logic [4:0] r, w;
		for (int i = 0; i < BANKS; i++) begin
			hit = cmd_vld && (item.cmd_bank == BANK_W'(i));
			a = bank_act_q[i];
			p = bank_pre_q[i];
			r = bank_rd_q[i];
			w = bank_wr_q[i];
			if (hit && a < lim_act) a = lim_act;
			if (hit && p < lim_pre) p = lim_pre;
			if (hit && r < lim_rw)  r = lim_rw;
			if (hit && w < lim_rw)  w = lim_rw;
			flags[i][0] = (a == '0) && (bus_act_n == '0);
			flags[i][1] = (p == '0);
			flags[i][2] = (r == '0) && (bus_rd_n == '0);
			flags[i][3] = (w == '0) && (bus_wr_n == '0);
			bank_act_n[i] = (a == '0) ? '0 : a - 6'd1;
			bank_pre_n[i] = (p == '0) ? '0 : p - 6'd1;
			bank_rd_n[i]  = (r == '0) ? '0 : r - 5'd1;
			bank_wr_n[i]  = (w == '0) ? '0 : w - 5'd1;
		end
	end

	always_comb begin
		for (int i = 0; i < BANKS; i++) begin
			res_n.act_ok[i] = flags[i][0];
			res_n.pre_ok[i] = flags[i][1];
			res_n.rd_ok[i]  = flags[i][2];
			res_n.wr_ok[i]  = flags[i][3];
		end
		case (item.query_type)
			CMD_ACT: res_n.query_allowed = flags[item.query_bank][0];
			CMD_PRE: res_n.query_allowed = flags[item.query_bank][1];
			CMD_RD:  res_n.query_allowed = flags[item.query_bank][2];
			CMD_WR:  res_n.query_allowed = flags[item.query_bank][3];
			default: res_n.query_allowed = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_act_q <= '0;
			bus_rd_q  <= '0;
			bus_wr_q  <= '0;
			res_q     <= '0;
			for (int i = 0; i < BANKS; i++) begin
				bank_act_q[i] <= '0;
				bank_pre_q[i] <= '0;
				bank_rd_q[i]  <= '0;
				bank_wr_q[i]  <= '0;
			end
		end else if (adv) begin
			bus_act_q <= bus_act_n;
			bus_rd_q  <= bus_rd_n;
			bus_wr_q  <= bus_wr_n;
			res_q     <= res_n;
			for (int i = 0; i < BANKS; i++) begin
				bank_act_q[i] <= bank_act_n[i];
				bank_pre_q[i] <= bank_pre_n[i];
				bank_rd_q[i]  <= bank_rd_n[i];
				bank_wr_q[i]  <= bank_wr_n[i];
			end
		end
	end

	// a read or write raises the write wait at least as far as the read wait
	a_wr_covers_rd: assert property (@(posedge clk) disable iff (!arst_n)
		7'(bus_rd_q) <= bus_wr_q)
		else $error("bus write wait below bus read wait");

	a_bus_act_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(bus_act_q != '0) |-> (res_q.act_ok == '0))
		else $error("activate allowed while bus activate wait pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(bus_wr_q) && $stable(bus_act_q) && $stable(res_q)))
		else $error("timer state changed without an item");

endmodule

// ----- sv/sdram_command_timing_checker.sv -----
// SDRAM command timing checker.
// Input channel (in_valid / in_stall): one item per memory clock tick, carrying
// the command seen on the bus (chip select, clock enable, type, bank, burst
// length) and one query (type, bank).
// Output channel (out_valid / out_stall): one result per item, in order: per
// bank activate / precharge / read / write permission masks for the next tick
// and the answer to the query.
// An accepted item passes through one input register, then the counter update
// and flag logic feeding the result register.
// Throughput is one item per cycle without receiver stalls; the wait counters
// update in a single pass per item, so a new item may be taken every cycle.
// When the receiver stalls, the result register holds and one more item waits
// in the input register; in_stall rises only while both are full.
// Reset clears all wait counters and masks (nothing allowed) and loads the
// timing registers with their defaults. Timing registers are written through
// cfg_we / cfg_idx / cfg_wdata and should change only while the block is idle.
module sdram_command_timing_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_idx,
	input  logic [5:0]                  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        chip_select_n,
	input  logic                        clock_enable,
	input  logic [2:0]                  req_type,
	input  logic [sctc_pkg::BANK_W-1:0] cmd_bank,
	input  logic [3:0]                  cas_length,
	input  logic [2:0]                  query_type,
	input  logic [sctc_pkg::BANK_W-1:0] query_bank,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sctc_pkg::BANKS-1:0]  activate_ok_banks,
	output logic [sctc_pkg::BANKS-1:0]  precharge_ok_banks,
	output logic [sctc_pkg::BANKS-1:0]  read_ok_banks,
	output logic [sctc_pkg::BANKS-1:0]  write_ok_banks,
	output logic                        query_allowed
);
	import sctc_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    vld_s1;
	logic    out_vld_q;
	logic    adv;
	logic    accept;
	result_t res;

	assign adv      = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.t_rc  <= 6'd10;
			cfg_q.t_rcd <= 5'd3;
			cfg_q.t_ras <= 6'd7;
			cfg_q.t_rp  <= 5'd3;
			cfg_q.t_rrd <= 5'd2;
			cfg_q.t_wr  <= 5'd2;
			cfg_q.t_cl  <= 5'd3;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_T_RC:  cfg_q.t_rc  <= cfg_wdata;
				REG_T_RCD: cfg_q.t_rcd <= cfg_wdata[4:0];
				REG_T_RAS: cfg_q.t_ras <= cfg_wdata;
				REG_T_RP:  cfg_q.t_rp  <= cfg_wdata[4:0];
				REG_T_RRD: cfg_q.t_rrd <= cfg_wdata[4:0];
				REG_T_WR:  cfg_q.t_wr  <= cfg_wdata[4:0];
				REG_T_CL:  cfg_q.t_cl  <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept)
				vld_s1 <= 1'b1;
			else if (adv)
				vld_s1 <= 1'b0;
			if (adv)
				out_vld_q <= 1'b1;
			else if (!out_stall)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.chip_select_n <= chip_select_n;
			item_s1.clock_enable  <= clock_enable;
			item_s1.req_type      <= req_type;
			item_s1.cmd_bank      <= cmd_bank;
			item_s1.cas_length    <= cas_length;
			item_s1.query_type    <= query_type;
			item_s1.query_bank    <= query_bank;
		end
	end

	sctc_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res_q  (res)
	);

	assign out_valid          = out_vld_q;
	assign activate_ok_banks  = res.act_ok;
	assign precharge_ok_banks = res.pre_ok;
	assign read_ok_banks      = res.rd_ok;
	assign write_ok_banks     = res.wr_ok;
	assign query_allowed      = res.query_allowed;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && out_vld_q && out_stall))
		else $error("input stalled with room in the pipeline");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_vld_q)
		else $error("item advanced but no result presented");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import sctc_pkg::*;

	typedef enum int {WAIT_ACT, WAIT_PRE, WAIT_RD, WAIT_WR} wait_kind_t;

	class permission_scoreboard;
		int unsigned t_rc, t_rcd, t_ras, t_rp, t_rrd, t_wr, t_cl;
		int unsigned bus_wait[4];
		int unsigned bank_wait[BANKS][4];
		bit [3:0] perm_flags[BANKS];
		result_t expected_masks[$];
		int errors;

		function new();
			t_rc = 10; t_rcd = 3; t_ras = 7; t_rp = 3; t_rrd = 2; t_wr = 2; t_cl = 3;
			foreach (bus_wait[k]) bus_wait[k] = 0;
			foreach (bank_wait[b, k]) bank_wait[b][k] = 0;
			foreach (perm_flags[b]) perm_flags[b] = '0;
			errors = 0;
		endfunction

		function int unsigned sat_dec(int unsigned v);
			return (v > 0) ? v - 1 : 0;
		endfunction

		function void set_reg(reg_idx_t idx, int unsigned value);
			case (idx)
				REG_T_RC:  t_rc  = value;
				REG_T_RCD: t_rcd = value;
				REG_T_RAS: t_ras = value;
				REG_T_RP:  t_rp  = value;
				REG_T_RRD: t_rrd = value;
				REG_T_WR:  t_wr  = value;
				REG_T_CL:  t_cl  = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_masks.size();
		endfunction

		// one tick of the timing counters; queues the masks the block should show
		function void note_command(item_t it);
			bit live;
			int unsigned bus_lim[4];
			int unsigned bank_lim[4];
			int unsigned c, v;
			bit [3:0] f;
			result_t r;
			live = !it.chip_select_n && it.clock_enable;
			foreach (bus_lim[k]) begin
				bus_lim[k] = 0;
				bank_lim[k] = 0;
			end
			case (it.req_type) inside
				CMD_ACT: begin
					if (t_rcd + t_rp < t_rc)
						bank_lim[WAIT_ACT] = sat_dec(t_rc);
					bank_lim[WAIT_RD] = sat_dec(t_rcd);
					bank_lim[WAIT_WR] = sat_dec(t_rcd);
					bank_lim[WAIT_PRE] = sat_dec(t_ras);
					bus_lim[WAIT_ACT] = sat_dec(t_rrd);
				end
				CMD_PRE: bank_lim[WAIT_ACT] = sat_dec(t_rp);
				CMD_RD, CMD_WR: begin
					c = sat_dec(it.cas_length);
					if (c > CAS_LIMIT - 1)
						c = CAS_LIMIT - 1;
					bank_lim[WAIT_PRE] = c;
					bus_lim[WAIT_RD] = c;
					bus_lim[WAIT_WR] = c;
					if (it.req_type == CMD_RD)
						bus_lim[WAIT_WR] = c + t_wr + t_cl;
				end
				default: ;
			endcase
			// bus counters: count down first, then raise
			foreach (bus_wait[k]) begin
				bus_wait[k] = sat_dec(bus_wait[k]);
				if (live && bus_wait[k] < bus_lim[k])
					bus_wait[k] = bus_lim[k];
			end
			r = '0;
			// bank counters: raise, take the flag, then count down
			for (int b = 0; b < BANKS; b++) begin
				f = '0;
				for (int k = 0; k < 4; k++) begin
					v = bank_wait[b][k];
					if (live && b == it.cmd_bank && v < bank_lim[k])
						v = bank_lim[k];
					f[k] = (v == 0) && (bus_wait[k] == 0);
					bank_wait[b][k] = sat_dec(v);
				end
				perm_flags[b] = f;
				r.act_ok[b] = f[WAIT_ACT];
				r.pre_ok[b] = f[WAIT_PRE];
				r.rd_ok[b]  = f[WAIT_RD];
				r.wr_ok[b]  = f[WAIT_WR];
			end
			if (it.query_type >= CMD_ACT && it.query_type <= CMD_WR)
				r.query_allowed = perm_flags[it.query_bank][it.query_type - 3'd1];
			else
				r.query_allowed = 1'b1;
			expected_masks.push_back(r);
		endfunction

		task report(string msg);
			$display("%0t ERROR %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, int unsigned want, int unsigned got);
			if (want != got)
				report($sformatf("%s: expected %0h, got %0h", name, want, got));
		endtask

		task check_masks(result_t got);
			result_t want;
			if (expected_masks.size() == 0) begin
				report("result with no item pending");
				return;
			end
			want = expected_masks.pop_front();
			compare_field("activate_ok_banks", want.act_ok, got.act_ok);
			compare_field("precharge_ok_banks", want.pre_ok, got.pre_ok);
			compare_field("read_ok_banks", want.rd_ok, got.rd_ok);
			compare_field("write_ok_banks", want.wr_ok, got.wr_ok);
			compare_field("query_allowed", want.query_allowed, got.query_allowed);
		endtask
	endclass

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              cfg_we        = 1'b0;
	logic [2:0]        cfg_idx       = '0;
	logic [5:0]        cfg_wdata     = '0;
	logic              in_valid      = 1'b0;
	logic              in_stall;
	logic              chip_select_n = 1'b1;
	logic              clock_enable  = 1'b0;
	logic [2:0]        req_type      = '0;
	logic [BANK_W-1:0] cmd_bank      = '0;
	logic [3:0]        cas_length    = '0;
	logic [2:0]        query_type    = '0;
	logic [BANK_W-1:0] query_bank    = '0;
	logic              out_valid;
	logic              out_stall     = 1'b0;
	logic [BANKS-1:0]  activate_ok_banks;
	logic [BANKS-1:0]  precharge_ok_banks;
	logic [BANKS-1:0]  read_ok_banks;
	logic [BANKS-1:0]  write_ok_banks;
	logic              query_allowed;

	permission_scoreboard sb;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	sdram_command_timing_checker dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_idx            (cfg_idx),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.chip_select_n      (chip_select_n),
		.clock_enable       (clock_enable),
		.req_type           (req_type),
		.cmd_bank           (cmd_bank),
		.cas_length         (cas_length),
		.query_type         (query_type),
		.query_bank         (query_bank),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.activate_ok_banks  (activate_ok_banks),
		.precharge_ok_banks (precharge_ok_banks),
		.read_ok_banks      (read_ok_banks),
		.write_ok_banks     (write_ok_banks),
		.query_allowed      (query_allowed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	// result monitor and receiver stall
	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.act_ok = activate_ok_banks;
			got.pre_ok = precharge_ok_banks;
			got.rd_ok = read_ok_banks;
			got.wr_ok = write_ok_banks;
			got.query_allowed = query_allowed;
			sb.check_masks(got);
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task send_item(item_t it);
		chip_select_n <= it.chip_select_n;
		clock_enable <= it.clock_enable;
		req_type <= it.req_type;
		cmd_bank <= it.cmd_bank;
		cas_length <= it.cas_length;
		query_type <= it.query_type;
		query_bank <= it.query_bank;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_command(it);
	endtask

	task send_cmd(bit cs_n, bit cke, logic [2:0] req, int bank, int cas, logic [2:0] qt,
			int qb);
		item_t it;
		it.chip_select_n = cs_n;
		it.clock_enable = cke;
		it.req_type = req;
		it.cmd_bank = BANK_W'(bank);
		it.cas_length = 4'(cas);
		it.query_type = qt;
		it.query_bank = BANK_W'(qb);
		send_item(it);
	endtask

	function item_t random_command();
		item_t it;
		int pick;
		it.chip_select_n = ($urandom_range(99) < 8);
		it.clock_enable = ($urandom_range(99) >= 8);
		pick = $urandom_range(99);
		if (pick < 40)      it.req_type = CMD_OTHER;
		else if (pick < 52) it.req_type = CMD_ACT;
		else if (pick < 64) it.req_type = CMD_PRE;
		else if (pick < 76) it.req_type = CMD_RD;
		else if (pick < 88) it.req_type = CMD_WR;
		else                it.req_type = 3'($urandom_range(7, CMD_WR + 1));
		it.cmd_bank = BANK_W'($urandom_range(BANKS - 1));
		if ($urandom_range(99) < 85)
			it.cas_length = 4'($urandom_range(CAS_LIMIT, 1));
		else
			it.cas_length = 4'($urandom_range(15));
		if ($urandom_range(99) < 80)
			it.query_type = 3'($urandom_range(CMD_WR, CMD_ACT));
		else
			it.query_type = 3'($urandom_range(7));
		it.query_bank = BANK_W'($urandom_range(BANKS - 1));
		return it;
	endfunction

	task write_reg(reg_idx_t idx, int unsigned value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= 6'(value);
		@(posedge clk);
		sb.set_reg(idx, value);
		cfg_we <= 1'b0;
	endtask

	task apply_timing(int ph);
		cfg_t c;
		case (ph)
			0: c = '{t_rc: 10, t_rcd: 3, t_ras: 7, t_rp: 3, t_rrd: 2, t_wr: 2, t_cl: 3};
			1: c = '{t_rc: 63, t_rcd: 31, t_ras: 63, t_rp: 31, t_rrd: 31, t_wr: 31, t_cl: 31};
			2: c = '{t_rc: 1, t_rcd: 1, t_ras: 1, t_rp: 1, t_rrd: 1, t_wr: 0, t_cl: 0};
			3: c = '0;
			4: begin
				c.t_rc = 6'($urandom_range(12, 1));
				c.t_rcd = 5'($urandom_range(6, 1));
				c.t_ras = 6'($urandom_range(12, 1));
				c.t_rp = 5'($urandom_range(6, 1));
				c.t_rrd = 5'($urandom_range(6, 1));
				c.t_wr = 5'($urandom_range(6));
				c.t_cl = 5'($urandom_range(6));
			end
			default: begin
				c.t_rc = 6'($urandom_range(63, 1));
				c.t_rcd = 5'($urandom_range(31, 1));
				c.t_ras = 6'($urandom_range(63, 1));
				c.t_rp = 5'($urandom_range(31, 1));
				c.t_rrd = 5'($urandom_range(31, 1));
				c.t_wr = 5'($urandom_range(31));
				c.t_cl = 5'($urandom_range(31));
			end
		endcase
		write_reg(REG_T_RC, c.t_rc);
		write_reg(REG_T_RCD, c.t_rcd);
		write_reg(REG_T_RAS, c.t_ras);
		write_reg(REG_T_RP, c.t_rp);
		write_reg(REG_T_RRD, c.t_rrd);
		write_reg(REG_T_WR, c.t_wr);
		write_reg(REG_T_CL, c.t_cl);
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task run_random(int n);
		for (int i = 0; i < n; i++) begin
			send_item(random_command());
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: burst length extremes, every command and query code, masked commands
		send_cmd(0, 1, CMD_OTHER, 0, 1, CMD_OTHER, 0);
		send_cmd(0, 1, CMD_ACT, 0, 1, CMD_ACT, 0);
		send_cmd(0, 1, CMD_RD, 0, 8, CMD_RD, 0);
		send_cmd(0, 1, CMD_WR, 1, 0, CMD_WR, 1);
		send_cmd(0, 1, CMD_RD, 2, 15, CMD_PRE, 2);
		send_cmd(0, 1, CMD_WR, 3, 9, CMD_WR + 3'd1, 3);
		send_cmd(0, 1, CMD_PRE, 3, 1, CMD_WR + 3'd2, 3);
		send_cmd(1, 1, CMD_ACT, 3, 1, CMD_WR + 3'd3, 3);
		send_cmd(0, 0, CMD_ACT, 2, 1, CMD_ACT, 2);
		send_cmd(1, 0, CMD_ACT, 1, 1, CMD_ACT, 1);
		for (int u = CMD_WR + 1; u < 8; u++)
			send_cmd(0, 1, 3'(u), 0, 15, 3'(u), 3);
		for (int i = 0; i < 10; i++)
			send_cmd(0, 1, CMD_OTHER, 0, 0, 3'(CMD_ACT + i % 4), i % BANKS);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			apply_timing(ph);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			run_random(235);
			drain();
		end

		recv_stall_pct = 0;
		repeat (6) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ----- sdram_command_timing_checker.f -----
sv/sctc_pkg.sv
sv/sctc_timer.sv
sv/sdram_command_timing_checker.sv
dv/tb_top.sv
